### hdl/mmvf_pkg.sv
package mmvf_pkg;

	// Configuration port geometry
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	// Register indexes on the configuration port
	typedef enum logic [2:0] {
		REG_TARGET_VALID    = 3'd0,
		REG_TARGET_MATERIAL = 3'd1,
		REG_FILTER_MODE     = 3'd2,
		REG_VERTEX_MORPH    = 3'd3,
		REG_VERTEX_COUNT    = 3'd4
	} reg_idx_t;

	// Input operation codes
	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_BEGIN  = 2'd1,
		OP_INDEX  = 2'd2,
		OP_OFFSET = 2'd3
	} op_t;

	// Command kinds passed from front to back
	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_MARK   = 2'd1,
		CMD_OFFSET = 2'd2
	} kind_t;

	typedef struct packed {
		logic        target_valid;
		logic [7:0]  target_material;
		logic [1:0]  filter_mode;
		logic        vertex_morph;
		logic [16:0] vertex_count;
	} cfg_t;

	typedef struct packed {
		kind_t              kind;
		logic               in_range;
		logic               sel;
		logic               trivial;
		logic               keep_only;
		logic               exclusive;
		logic signed [31:0] vertex;
	} cmd_t;

endpackage

### hdl/morph_material_vertex_filter.sv
// Morph material vertex filter. Configure the target material, filter mode,
// morph kind and vertex count over the APB port while the block is idle, then
// issue items with start while busy is low. After reset, and after every clear
// item reaches the back end and earlier work drains, the whole vertex store
// is swept and busy stays high during the sweep. Begin, index and offset items
// are taken one per cycle while busy is low; in-range index entries still owed
// each make one read-modify-write, and offsets one read, of the vertex store
// (one write and one read port) in a two-stage pipeline with forwarding, so
// back-to-back entries on the same vertex are fine. A two-entry queue sits
// between the classifier and the store, and busy rises when it fills. Each
// offset yields one result with done high for one cycle; results cannot be
// held off, so the receiver must take every strobe.
module morph_material_vertex_filter import mmvf_pkg::*; #(
	parameter int VERTICES  = 65536,
	parameter int MATERIALS = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         operation,
	input  logic [30:0]        index_count,
	input  logic signed [31:0] vertex,
	output logic               done,
	output logic               keep,
	output logic signed [31:0] vertex_echo
);

	localparam int MW = $clog2(MATERIALS);
	localparam int QW = $bits(cmd_t) + MW;

	cfg_t          cfg_q;
	reg_idx_t      idx;
	logic          wr_en;
	logic          accept;
	logic          push;
	cmd_t          push_cmd;
	logic [MW-1:0] push_mat;
	logic [QW-1:0] head;
	logic          pop;
	logic          empty;
	logic          full;
	logic          clearing;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign accept = start && !busy;
	assign busy   = full || clearing;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_valid    <= 1'b0;
			cfg_q.target_material <= 8'd0;
			cfg_q.filter_mode     <= 2'd0;
			cfg_q.vertex_morph    <= 1'b1;
			cfg_q.vertex_count    <= 17'd0;
		end else if (wr_en) begin
			case (idx)
				REG_TARGET_VALID:    cfg_q.target_valid    <= pwdata[0];
				REG_TARGET_MATERIAL: cfg_q.target_material <= pwdata[7:0];
				REG_FILTER_MODE:     cfg_q.filter_mode     <= pwdata[1:0];
				REG_VERTEX_MORPH:    cfg_q.vertex_morph    <= pwdata[0];
				REG_VERTEX_COUNT:    cfg_q.vertex_count    <= pwdata[16:0];
				default:             cfg_q                 <= cfg_q;
			endcase
		end
	end

	// Read back configuration registers
	always_comb begin
		case (idx)
			REG_TARGET_VALID:    prdata = DATA_W'(cfg_q.target_valid);
			REG_TARGET_MATERIAL: prdata = DATA_W'(cfg_q.target_material);
			REG_FILTER_MODE:     prdata = DATA_W'(cfg_q.filter_mode);
			REG_VERTEX_MORPH:    prdata = DATA_W'(cfg_q.vertex_morph);
			REG_VERTEX_COUNT:    prdata = DATA_W'(cfg_q.vertex_count);
			default:             prdata = '0;
		endcase
	end

	mmvf_front #(
		.VERTICES  (VERTICES),
		.MATERIALS (MATERIALS),
		.MW        (MW)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.accept      (accept),
		.operation   (operation),
		.index_count (index_count),
		.vertex      (vertex),
		.push        (push),
		.push_cmd    (push_cmd),
		.push_mat    (push_mat)
	);

	mmvf_queue #(
		.W (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_cmd, push_mat}),
		.pop       (pop),
		.head      (head),
		.empty     (empty),
		.full      (full)
	);

	mmvf_back #(
		.VERTICES  (VERTICES),
		.MATERIALS (MATERIALS),
		.MW        (MW)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.empty       (empty),
		.head_cmd    (cmd_t'(head[QW-1:MW])),
		.head_mat    (head[MW-1:0]),
		.pop         (pop),
		.clearing    (clearing),
		.done        (done),
		.keep        (keep),
		.vertex_echo (vertex_echo)
	);

endmodule

### hdl/mmvf_front.sv
module mmvf_front import mmvf_pkg::*; #(
	parameter int VERTICES  = 65536,
	parameter int MATERIALS = 256,
	parameter int MW        = $clog2(MATERIALS)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               accept,
	input  logic [1:0]         operation,
	input  logic [30:0]        index_count,
	input  logic signed [31:0] vertex,
	output logic               push,
	output cmd_t               push_cmd,
	output logic [MW-1:0]      push_mat
);

	localparam int CW = $clog2(MATERIALS + 1);

	logic [CW-1:0] begun_q;
	logic [30:0]   left_q;
	logic [CW-1:0] begun_m1;
	logic [31:0]   vu;
	logic          in_range;
	logic          trivial;
	kind_t         kind;

	// Classify the vertex and the target against current state
	assign vu       = vertex;
	assign in_range = !vu[31] && (vu < 32'(cfg.vertex_count)) && (vu < 32'(VERTICES));
	assign begun_m1 = begun_q - CW'(1);
	assign push_mat = begun_m1[MW-1:0];
	assign trivial  = !cfg.target_valid || !cfg.vertex_morph ||
		(32'(cfg.target_material) >= 32'(begun_q));

	assign push_cmd.kind      = kind;
	assign push_cmd.in_range  = in_range;
	assign push_cmd.sel       = (32'(push_mat) == 32'(cfg.target_material));
	assign push_cmd.trivial   = trivial;
	assign push_cmd.keep_only = cfg.filter_mode[0];
	assign push_cmd.exclusive = cfg.filter_mode[1];
	assign push_cmd.vertex    = vertex;

	// Pick the command kind and whether it goes to the back end
	always_comb begin
		push = 1'b0;
		kind = CMD_OFFSET;
		case (op_t'(operation))
			OP_CLEAR: begin
				push = accept;
				kind = CMD_CLEAR;
			end
			OP_BEGIN: begin
				push = 1'b0;
			end
			OP_INDEX: begin
				push = accept && (left_q != 31'd0) && in_range;
				kind = CMD_MARK;
			end
			OP_OFFSET: begin
				push = accept;
				kind = CMD_OFFSET;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	// Track materials begun and index entries still owed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			begun_q <= '0;
			left_q  <= '0;
		end else if (accept) begin
			case (op_t'(operation))
				OP_CLEAR: begin
					begun_q <= '0;
					left_q  <= '0;
				end
				OP_BEGIN: begin
					if (begun_q < CW'(MATERIALS)) begin
						begun_q <= begun_q + CW'(1);
						left_q  <= index_count;
					end else begin
						left_q <= '0;
					end
				end
				OP_INDEX: begin
					if (left_q != 31'd0) begin
						left_q <= left_q - 31'd1;
					end
				end
				default: begin
					left_q <= left_q;
				end
			endcase
		end
	end

endmodule

### hdl/mmvf_queue.sv
module mmvf_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic [W-1:0] head,
	output logic         empty,
	output logic         full
);

	logic [W-1:0] slot_q [2];
	logic         wr_q;
	logic         rd_q;
	logic [1:0]   count_q;

	assign head  = slot_q[rd_q];
	assign empty = (count_q == 2'd0);
	assign full  = (count_q == 2'd2);

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Hold the transaction payloads
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

endmodule

### hdl/mmvf_back.sv
module mmvf_back import mmvf_pkg::*; #(
	parameter int VERTICES  = 65536,
	parameter int MATERIALS = 256,
	parameter int MW        = $clog2(MATERIALS)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               empty,
	input  cmd_t               head_cmd,
	input  logic [MW-1:0]      head_mat,
	output logic               pop,
	output logic               clearing,
	output logic               done,
	output logic               keep,
	output logic signed [31:0] vertex_echo
);

	localparam int AW = $clog2(VERTICES);
	// Entry: seen, selected, multiple materials, first material
	localparam int EW = MW + 3;

	typedef enum logic {
		ST_CLEAR,
		ST_RUN
	} state_t;

	state_t        state_q;
	logic [AW-1:0] sweep_q;

	logic [EW-1:0] mem_q [VERTICES];

	logic          valid_s1;
	cmd_t          cmd_s1;
	logic [MW-1:0] mat_s1;
	logic          valid_s2;
	cmd_t          cmd_s2;
	logic [MW-1:0] mat_s2;
	logic [EW-1:0] rdata_s2;
	logic [EW-1:0] fwd_s2;
	logic          fwd_use_s2;

	logic          done_q;
	logic          keep_q;
	logic [31:0]   echo_q;

	logic [AW-1:0] addr_s1;
	logic [AW-1:0] addr_s2;
	logic [EW-1:0] cur;
	logic [EW-1:0] upd;
	logic          mark_s2;
	logic          hit;
	logic          keep_d;
	logic          head_clear;
	logic          drained;
	logic          we;
	logic [AW-1:0] waddr;
	logic [EW-1:0] wdata;

	assign addr_s1    = cmd_s1.vertex[AW-1:0];
	assign addr_s2    = cmd_s2.vertex[AW-1:0];
	assign head_clear = (head_cmd.kind == CMD_CLEAR);
	assign drained    = !valid_s1 && !valid_s2;
	assign pop        = (state_q == ST_RUN) && !empty && (!head_clear || drained);
	assign clearing   = (state_q == ST_CLEAR);

	// Merge the stored entry with the newest write to the same vertex
	assign cur     = fwd_use_s2 ? fwd_s2 : rdata_s2;
	assign mark_s2 = valid_s2 && (cmd_s2.kind == CMD_MARK);

	always_comb begin
		upd = cur;
		if (cmd_s2.sel) begin
			upd[EW-2] = 1'b1;
		end
		if (!cur[EW-1]) begin
			upd[EW-1]   = 1'b1;
			upd[MW-1:0] = mat_s2;
		end else if (cur[MW-1:0] != mat_s2) begin
			upd[EW-3] = 1'b1;
		end
	end

	// Decide keep or drop for an offset
	assign hit    = cmd_s2.in_range && cur[EW-2] && (!cmd_s2.exclusive || !cur[EW-3]);
	assign keep_d = cmd_s2.trivial || (cmd_s2.keep_only ? hit : !hit);

	// Sweep writes zeros; otherwise the second stage writes back index entries
	assign we    = clearing || mark_s2;
	assign waddr = clearing ? sweep_q : addr_s2;
	assign wdata = clearing ? '0 : upd;

	// Hold state, valid bits and the result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			sweep_q  <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					sweep_q <= sweep_q + AW'(1);
					if (sweep_q == AW'(VERTICES - 1)) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (pop && head_clear) begin
						state_q <= ST_CLEAR;
						sweep_q <= '0;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
			valid_s1 <= pop && !head_clear;
			valid_s2 <= valid_s1;
			done_q   <= valid_s2 && (cmd_s2.kind == CMD_OFFSET);
		end
	end

	// Advance payloads through the read-modify-write stages
	always_ff @(posedge clk) begin
		cmd_s1     <= head_cmd;
		mat_s1     <= head_mat;
		cmd_s2     <= cmd_s1;
		mat_s2     <= mat_s1;
		fwd_s2     <= upd;
		fwd_use_s2 <= mark_s2 && valid_s1 && (addr_s1 == addr_s2);
		keep_q     <= keep_d;
		echo_q     <= cmd_s2.vertex;
	end

	// Vertex store: one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_s2 <= mem_q[addr_s1];
	end

	assign done        = done_q;
	assign keep        = keep_q;
	assign vertex_echo = echo_q;

endmodule
